// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the distance edge sorter.
// Depends on nothing; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// Condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	`ASSERT_CLK(lbl, clk, rst_n, !(cond))
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/des_pkg.sv =====
// Package for the distance edge sorter: widths, key type, sequencer states.
// Depends on nothing.
`timescale 1ns / 1ps
package des_pkg;

	localparam int DIST_W          = 32;
	localparam int NODE_W          = 16;
	localparam int KEY_W           = DIST_W + 2 * NODE_W;
	localparam int MAX_ENTRIES_DEF = 64;

	// Packed sort key: distance, lower node, higher node (MSB first)
	typedef logic [KEY_W-1:0] key_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_EMIT
	} des_state_t;

endpackage

// ===== rtl/des_if.sv =====
// Valid/ready stream interfaces for entries in and sorted results out.
// Depends on des_pkg for field widths.
`timescale 1ns / 1ps
interface des_in_if;
	logic                         valid;
	logic                         ready;
	logic [des_pkg::DIST_W-1:0]   distance;
	logic [des_pkg::NODE_W-1:0]   node_low;
	logic [des_pkg::NODE_W-1:0]   node_high;
	logic                         last_entry;

	modport source (output valid, distance, node_low, node_high, last_entry, input ready);
	modport sink   (input valid, distance, node_low, node_high, last_entry, output ready);
endinterface

interface des_out_if;
	logic                         valid;
	logic                         ready;
	logic [des_pkg::DIST_W-1:0]   sorted_distance;
	logic [des_pkg::NODE_W-1:0]   sorted_low;
	logic [des_pkg::NODE_W-1:0]   sorted_high;
	logic                         last_result;
	logic                         dropped;

	modport source (output valid, sorted_distance, sorted_low, sorted_high, last_result,
		dropped, input ready);
	modport sink   (input valid, sorted_distance, sorted_low, sorted_high, last_result,
		dropped, output ready);
endinterface

// ===== rtl/des_store.sv =====
// Entry store: one write port, one read port, registered read data.
// Depends on des_pkg for the key type.
`timescale 1ns / 1ps
module des_store #(
	parameter int DEPTH = des_pkg::MAX_ENTRIES_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  des_pkg::key_t     wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output des_pkg::key_t     rdata
);

	des_pkg::key_t mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/des_seq.sv =====
// Load/sort sequencer: fills the store, then selection-sorts it,
// one memory read per cycle while scanning, and drives the result register.
// Depends on des_pkg, des_if and assert_macros.svh; reaches des_store through the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module des_seq #(
	parameter int MAX_ENTRIES = des_pkg::MAX_ENTRIES_DEF,
	localparam int AW = $clog2(MAX_ENTRIES),
	localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	des_in_if.sink            entries,
	des_out_if.source         results,
	output logic              mem_we,
	output logic [AW-1:0]     mem_waddr,
	output des_pkg::key_t     mem_wdata,
	output logic              mem_re,
	output logic [AW-1:0]     mem_raddr,
	input  des_pkg::key_t     mem_rdata
);

	des_pkg::des_state_t state_q, state_d;

	logic [CW-1:0]  count_q;      // stored entries; set size while sorting
	logic           ovf_q;
	logic [CW-1:0]  rank_q;       // rank being resolved
	logic [CW-1:0]  addr_q;       // next read address of the scan
	logic           rd_v_s1;
	logic [CW-1:0]  rd_idx_s1;
	des_pkg::key_t  best_q;
	logic [AW-1:0]  best_idx_q;
	des_pkg::key_t  head_q;       // entry that sat at the rank position

	logic           in_fire;
	logic           room;
	logic           scan_done;
	logic           emit_fire;
	logic           rank_last;
	logic [CW-1:0]  count_m1;

	logic           out_valid_q;
	des_pkg::key_t  out_key_q;
	logic           out_last_q;
	logic           out_drop_q;

	des_pkg::key_t  in_key;

	assign in_key    = {entries.distance, entries.node_low, entries.node_high};
	assign room      = (count_q < CW'(MAX_ENTRIES));
	assign count_m1  = CW'(count_q - CW'(1));
	assign rank_last = (rank_q == count_m1);
	assign scan_done = rd_v_s1 && (rd_idx_s1 == count_m1);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			des_pkg::ST_LOAD: begin
				if (in_fire && entries.last_entry) begin
					state_d = des_pkg::ST_SCAN;
				end
			end
			des_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = des_pkg::ST_EMIT;
				end
			end
			des_pkg::ST_EMIT: begin
				if (emit_fire) begin
					state_d = rank_last ? des_pkg::ST_LOAD : des_pkg::ST_SCAN;
				end
			end
			default: state_d = des_pkg::ST_LOAD;
		endcase
	end

	// State outputs: handshake, memory ports
	always_comb begin
		entries.ready = 1'b0;
		in_fire       = 1'b0;
		emit_fire     = 1'b0;
		mem_we        = 1'b0;
		mem_waddr     = count_q[AW-1:0];
		mem_wdata     = in_key;
		mem_re        = 1'b0;
		mem_raddr     = addr_q[AW-1:0];
		unique case (state_q)
			des_pkg::ST_LOAD: begin
				entries.ready = 1'b1;
				in_fire       = entries.valid;
				mem_we        = entries.valid && room;
			end
			des_pkg::ST_SCAN: begin
				mem_re = (addr_q < count_q);
			end
			des_pkg::ST_EMIT: begin
				emit_fire = !out_valid_q || results.ready;
				// half swap: the displaced head takes the winner's slot
				mem_we    = emit_fire;
				mem_waddr = best_idx_q;
				mem_wdata = head_q;
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= des_pkg::ST_LOAD;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			rank_q    <= '0;
			addr_q    <= '0;
			rd_v_s1   <= 1'b0;
			rd_idx_s1 <= '0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= mem_re;
			if (mem_re) begin
				rd_idx_s1 <= addr_q;
				addr_q    <= CW'(addr_q + CW'(1));
			end
			if (in_fire) begin
				if (room) begin
					count_q <= CW'(count_q + CW'(1));
				end else begin
					ovf_q <= 1'b1;
				end
				if (entries.last_entry) begin
					rank_q <= '0;
					addr_q <= '0;
				end
			end
			if (emit_fire) begin
				rank_q <= CW'(rank_q + CW'(1));
				addr_q <= CW'(rank_q + CW'(1));
				if (rank_last) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end
			end
		end
	end

	// Running minimum over the scan
	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			priority if (rd_idx_s1 == rank_q) begin
				head_q     <= mem_rdata;
				best_q     <= mem_rdata;
				best_idx_q <= rd_idx_s1[AW-1:0];
			end else if (mem_rdata < best_q) begin
				best_q     <= mem_rdata;
				best_idx_q <= rd_idx_s1[AW-1:0];
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_key_q  <= best_q;
			out_last_q <= rank_last;
			out_drop_q <= ovf_q;
		end
	end

	assign results.valid           = out_valid_q;
	assign results.sorted_distance = out_key_q[des_pkg::KEY_W-1 -: des_pkg::DIST_W];
	assign results.sorted_low      = out_key_q[2*des_pkg::NODE_W-1 -: des_pkg::NODE_W];
	assign results.sorted_high     = out_key_q[des_pkg::NODE_W-1:0];
	assign results.last_result     = out_last_q;
	assign results.dropped         = out_drop_q;

	// Checks
	`ASSERT_NEVER(a_count_range, clk, arst_n, count_q > CW'(MAX_ENTRIES))
	`ASSERT_CLK(a_read_in_scan, clk, arst_n, rd_v_s1 |-> state_q == des_pkg::ST_SCAN)
	`ASSERT_CLK(a_sort_nonempty, clk, arst_n, state_q != des_pkg::ST_LOAD |-> count_q != '0)
	`ASSERT_CLK(a_winner_range, clk, arst_n,
		emit_fire |-> (CW'(best_idx_q) >= rank_q) && (CW'(best_idx_q) < count_q))
	`ASSERT_CLK(a_set_closes, clk, arst_n,
		emit_fire && rank_last |=> state_q == des_pkg::ST_LOAD && count_q == '0 && !ovf_q)

endmodule

// ===== rtl/distance_edge_sorter.sv =====
// Flow: entries load at one per cycle while the sequencer is loading; after
// the last entry of a set of n, each rank r scans entries r..n-1 through the
// single memory read port into a running minimum and then emits the winner,
// waiting while the result register is full and not being taken.
// Reset: arst_n clears the sequencer, counts and result valid; the store is
// not cleared and holds no meaning until loaded.
`timescale 1ns / 1ps
module distance_edge_sorter #(
	parameter int MAX_ENTRIES = des_pkg::MAX_ENTRIES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	des_in_if.sink    entries,
	des_out_if.source results
);

	localparam int AW = $clog2(MAX_ENTRIES);

	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	des_pkg::key_t  mem_wdata;
	logic           mem_re;
	logic [AW-1:0]  mem_raddr;
	des_pkg::key_t  mem_rdata;

	// Sequencer
	des_seq #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.entries   (entries),
		.results   (results),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Entry memory
	des_store #(
		.DEPTH (MAX_ENTRIES)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
